### hdl/fcull_pkg.sv
// Package for the frustum culling test: shared constants, the verdict codes
// and the item record that travels down the chain of plane cells.
// No dependencies.
`timescale 1ns / 1ps

package fcull_pkg;

  localparam int PLANE_REGS    = 6;
  localparam int PLANE_COUNT_D = 6;
  localparam int CFG_INDEX_W   = 3;
  localparam int PLANE_W       = 64;
  localparam int COORD_W       = 16;
  localparam int RADIUS_W      = 15;
  localparam int FRAC_BITS     = 14;
  localparam int PROD_W        = 2 * COORD_W;
  localparam int DIST_W        = PROD_W + 2;

  typedef enum logic [1:0] {
    VERDICT_INSIDE    = 2'd0,
    VERDICT_INTERSECT = 2'd1,
    VERDICT_OUTSIDE   = 2'd2
  } verdict_t;

  typedef enum logic [1:0] {
    REQ_POINT  = 2'd0,
    REQ_SPHERE = 2'd1,
    REQ_BOX    = 2'd2,
    REQ_SPARE  = 2'd3
  } req_t;

  typedef struct packed {
    logic                       valid;
    logic                       is_box;
    logic                       is_sphere;
    logic signed [COORD_W-1:0]  ax;
    logic signed [COORD_W-1:0]  ay;
    logic signed [COORD_W-1:0]  az;
    logic signed [COORD_W-1:0]  bx;
    logic signed [COORD_W-1:0]  by;
    logic signed [COORD_W-1:0]  bz;
    logic        [RADIUS_W-1:0] radius;
    verdict_t                   verdict;
  } item_t;

  function automatic verdict_t merge_verdict(verdict_t prev, logic fail, logic near_fail);
    verdict_t res;
    if (prev == VERDICT_OUTSIDE || fail) begin
      res = VERDICT_OUTSIDE;
    end else if (prev == VERDICT_INTERSECT || near_fail) begin
      res = VERDICT_INTERSECT;
    end else begin
      res = VERDICT_INSIDE;
    end
    return res;
  endfunction

endpackage

### hdl/fcull_cell.sv
// One plane cell of the culling chain: multiplies in the first stage, sums
// and classifies in the second, then hands the item to the next cell.
// Depends on fcull_pkg.
`timescale 1ns / 1ps

module fcull_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [fcull_pkg::PLANE_W-1:0]    plane,
  input  fcull_pkg::item_t                 item_in,
  output fcull_pkg::item_t                 item_out
);

  localparam int CW = fcull_pkg::COORD_W;
  localparam int PW = fcull_pkg::PROD_W;
  localparam int DW = fcull_pkg::DIST_W;
  localparam int RW = fcull_pkg::RADIUS_W + fcull_pkg::FRAC_BITS;

  typedef struct packed {
    fcull_pkg::item_t       item;
    logic signed [PW-1:0]   fx;
    logic signed [PW-1:0]   fy;
    logic signed [PW-1:0]   fz;
    logic signed [PW-1:0]   qx;
    logic signed [PW-1:0]   qy;
    logic signed [PW-1:0]   qz;
    logic signed [CW-1:0]   w;
    logic        [RW-1:0]   rad;
  } prod_t;

  logic signed [CW-1:0] nx, ny, nz, w;
  logic signed [CW-1:0] px, py, pz, vx, vy, vz;
  prod_t                s1_nxt, s1_r;
  fcull_pkg::item_t     s2_nxt, s2_r;
  logic        [DW-1:0] far_sum, near_sum, w_ext;

  assign nx = plane[CW-1:0];
  assign ny = plane[2*CW-1:CW];
  assign nz = plane[3*CW-1:2*CW];
  assign w  = plane[4*CW-1:3*CW];

  always_comb begin
    px = (item_in.is_box && !nx[CW-1] && nx != '0) ? item_in.bx : item_in.ax;
    py = (item_in.is_box && !ny[CW-1] && ny != '0) ? item_in.by : item_in.ay;
    pz = (item_in.is_box && !nz[CW-1] && nz != '0) ? item_in.bz : item_in.az;
    vx = (item_in.is_box && nx[CW-1]) ? item_in.bx : item_in.ax;
    vy = (item_in.is_box && ny[CW-1]) ? item_in.by : item_in.ay;
    vz = (item_in.is_box && nz[CW-1]) ? item_in.bz : item_in.az;
    s1_nxt.item       = item_in;
    s1_nxt.item.valid = rst_n && item_in.valid;
    s1_nxt.fx   = nx * px;
    s1_nxt.fy   = ny * py;
    s1_nxt.fz   = nz * pz;
    s1_nxt.qx   = nx * vx;
    s1_nxt.qy   = ny * vy;
    s1_nxt.qz   = nz * vz;
    s1_nxt.w    = w;
    s1_nxt.rad  = item_in.is_sphere ? {item_in.radius, {fcull_pkg::FRAC_BITS{1'b0}}} : '0;
  end

  always_comb begin
    w_ext    = {{(DW-CW){s1_r.w[CW-1]}}, s1_r.w};
    far_sum  = {{(DW-PW){s1_r.fx[PW-1]}}, s1_r.fx} + {{(DW-PW){s1_r.fy[PW-1]}}, s1_r.fy}
             + {{(DW-PW){s1_r.fz[PW-1]}}, s1_r.fz} + w_ext + {{(DW-RW){1'b0}}, s1_r.rad};
    near_sum = {{(DW-PW){s1_r.qx[PW-1]}}, s1_r.qx} + {{(DW-PW){s1_r.qy[PW-1]}}, s1_r.qy}
             + {{(DW-PW){s1_r.qz[PW-1]}}, s1_r.qz} + w_ext;
    s2_nxt         = s1_r.item;
    s2_nxt.valid   = rst_n && s1_r.item.valid;
    s2_nxt.verdict = fcull_pkg::merge_verdict(s1_r.item.verdict, far_sum[DW-1],
                                              s1_r.item.is_box && near_sum[DW-1]);
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    s2_r <= s2_nxt;
  end

  assign item_out = s2_r;

endmodule

### hdl/frustum_cull_test.sv
// Top level of the frustum culling test: plane registers and a chain of
// plane cells, one per tested plane. Depends on fcull_pkg and fcull_cell.
//
//   channel  | ports                                | transfer
//   ---------+--------------------------------------+------------------------------
//   input    | in_req_type, in_first_*, in_second_*, | start high while busy is low
//            | in_sphere_radius                     |
//   result   | out_verdict                          | out_valid high for one cycle
//   config   | cfg_we, cfg_index, cfg_data          | cfg_we high
//
// A new primitive can be taken every cycle; busy is always low.
// Each result passes through min(PLANE_COUNT, 6) plane cells after its input transfer,
// two pipeline stages per plane cell (multiply, then sum and classify).
// Synchronous reset clears the plane registers and the valid flags of the chain.
// The receiver cannot stall, so results leave in input order without holdup.
`timescale 1ns / 1ps

module frustum_cull_test #(
  parameter int PLANE_COUNT = fcull_pkg::PLANE_COUNT_D
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             in_req_type,
  input  logic signed [fcull_pkg::COORD_W-1:0]   in_first_x,
  input  logic signed [fcull_pkg::COORD_W-1:0]   in_first_y,
  input  logic signed [fcull_pkg::COORD_W-1:0]   in_first_z,
  input  logic signed [fcull_pkg::COORD_W-1:0]   in_second_x,
  input  logic signed [fcull_pkg::COORD_W-1:0]   in_second_y,
  input  logic signed [fcull_pkg::COORD_W-1:0]   in_second_z,
  input  logic [fcull_pkg::RADIUS_W-1:0]         in_sphere_radius,
  output logic                                   out_valid,
  output logic [1:0]                             out_verdict,
  input  logic                                   cfg_we,
  input  logic [fcull_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [fcull_pkg::PLANE_W-1:0]          cfg_data
);

  localparam int CELL_COUNT = (PLANE_COUNT < fcull_pkg::PLANE_REGS) ?
                              PLANE_COUNT : fcull_pkg::PLANE_REGS;

  logic [fcull_pkg::PLANE_W-1:0] planes_r [fcull_pkg::PLANE_REGS];
  fcull_pkg::item_t              head;
  fcull_pkg::item_t              chain [CELL_COUNT+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fcull_pkg::PLANE_REGS; i++) begin
        planes_r[i] <= '0;
      end
    end else if (cfg_we && cfg_index < fcull_pkg::CFG_INDEX_W'(fcull_pkg::PLANE_REGS)) begin
      planes_r[cfg_index] <= cfg_data;
    end
  end

  assign busy = 1'b0;

  always_comb begin
    head.valid     = start;
    head.is_box    = in_req_type == fcull_pkg::REQ_BOX;
    head.is_sphere = in_req_type == fcull_pkg::REQ_SPHERE;
    head.ax        = in_first_x;
    head.ay        = in_first_y;
    head.az        = in_first_z;
    head.bx        = in_second_x;
    head.by        = in_second_y;
    head.bz        = in_second_z;
    head.radius    = in_sphere_radius;
    head.verdict   = fcull_pkg::VERDICT_INSIDE;
  end

  assign chain[0] = head;

  for (genvar g = 0; g < CELL_COUNT; g++) begin : g_cell
    fcull_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .plane    (planes_r[g]),
      .item_in  (chain[g]),
      .item_out (chain[g+1])
    );
  end

  assign out_valid   = chain[CELL_COUNT].valid;
  assign out_verdict = chain[CELL_COUNT].verdict;

endmodule
